// File: rtl/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Types, character codes and saturating arithmetic shared by the source line
// classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int OUT_WIDTH   = 32;
	localparam int BYTE_WIDTH  = 8;

	localparam logic [BYTE_WIDTH-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_WIDTH-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_WIDTH-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_WIDTH-1:0] CH_SLASH = 8'h2F;
	localparam logic [BYTE_WIDTH-1:0] CH_STAR  = 8'h2A;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// Line and comment tracking state together with the four line counters.
	typedef struct packed {
		logic   line_empty;
		logic   line_slashes;
		logic   line_code;
		logic   in_block;
		count_t pending;
		count_t total;
		count_t empty_cnt;
		count_t effective;
		count_t comment;
	} slc_state_t;

	typedef struct packed {
		count_t total;
		count_t empty_cnt;
		count_t effective;
		count_t comment;
	} slc_counts_t;

	localparam slc_state_t SLC_RESET_STATE = '{
		line_empty:   1'b1,
		line_slashes: 1'b0,
		line_code:    1'b0,
		in_block:     1'b0,
		pending:      '0,
		total:        '0,
		empty_cnt:    '0,
		effective:    '0,
		comment:      '0
	};

	function automatic count_t sat_inc(input count_t a, input logic [1:0] d);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + {{(COUNT_WIDTH-1){1'b0}}, d};
		return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
	endfunction

	function automatic count_t sat_add(input count_t a, input count_t b);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
	endfunction

	function automatic logic is_blank(input logic [BYTE_WIDTH-1:0] p);
		return (p == CH_SPACE) || (p == CH_LF) || (p == CH_CR);
	endfunction

	// A non-blank byte that is not a comment character, outside any comment.
	function automatic logic makes_code(input slc_state_t st, input logic [BYTE_WIDTH-1:0] p);
		return !is_blank(p) && (p != CH_SLASH) && (p != CH_STAR)
			&& !st.in_block && !st.line_slashes;
	endfunction

endpackage

`default_nettype wire

// File: rtl/slc_settle.sv
// ----------------------------------------------------------------------------
// slc_settle
// Settles the last byte of a file against the tracking state and produces
// the four final line counts.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_settle
	import slc_pkg::*;
(
	input  wire slc_state_t              st,
	input  wire logic [BYTE_WIDTH-1:0]   last_byte,
	output slc_counts_t                  counts
);

	logic empty_now;
	logic code_now;
	logic is_lf;

	always_comb begin
		is_lf     = (last_byte == CH_LF);
		empty_now = st.line_empty && is_blank(last_byte);
		code_now  = st.line_code || makes_code(st, last_byte);

		// The last line always closes; a trailing line feed opens one more
		// empty line, which is counted as well.
		counts.total     = sat_inc(st.total, {is_lf, !is_lf});
		counts.empty_cnt = sat_inc(st.empty_cnt,
			{1'b0, empty_now} + {1'b0, is_lf});
		counts.effective = sat_inc(st.effective, {1'b0, code_now});
		counts.comment   = sat_inc(st.comment,
			{1'b0, st.line_slashes && !st.in_block});
	end

endmodule

`default_nettype wire

// File: rtl/source_line_classifier.sv
// ----------------------------------------------------------------------------
// source_line_classifier
// Counts total, empty, effective and comment lines of C-style source text.
// ----------------------------------------------------------------------------
// The file arrives one byte per item on the s_axis channel, with tlast on its
// final byte. Each byte is judged together with the byte that follows, so the
// block holds one byte back; comment openers and closers are two-byte pairs.
// One result item leaves on m_axis for every file, carrying the four counts.
// Counters saturate at all ones.
//
// Throughput is one byte per cycle while m_axis is not stalled: the tracking
// state is updated by a single pass of flag logic and one saturating add per
// counter in stage one. The final byte is settled in stage two from a snapshot,
// so the next file can start in the very next cycle. The result register
// follows stage two and holds the result item until it is taken.
//
// When m_axis_tready is low with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost. Reset (arst_n low) returns the
// tracking state and all counters to the start of a new file and empties the
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module source_line_classifier
	import slc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // [7:0] text_byte
	input  wire logic         s_axis_tlast,   // final_byte

	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [127:0]      m_axis_tdata    // [31:0] total_lines,
	                                          // [63:32] empty_lines,
	                                          // [95:64] effective_lines,
	                                          // [127:96] comment_lines
);

	logic                  en;

	logic                  valid_s1;
	logic [BYTE_WIDTH-1:0] byte_s1;
	logic                  last_s1;

	logic                  held_valid_q;
	logic [BYTE_WIDTH-1:0] held_q;
	slc_state_t            state_q;
	slc_state_t            judged;

	logic                  valid_s2;
	slc_state_t            snap_s2;
	logic [BYTE_WIDTH-1:0] byte_s2;

	slc_counts_t           counts;
	logic                  m_valid_q;
	logic [127:0]          m_data_q;

	assign en            = !m_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Judge the held byte, using the newly arrived byte as its successor.
	always_comb begin
		logic empty_now;
		logic code_now;
		judged    = state_q;
		empty_now = 1'b0;
		code_now  = 1'b0;
		if (held_valid_q) begin
			empty_now = state_q.line_empty && is_blank(held_q);
			code_now  = state_q.line_code || makes_code(state_q, held_q);
			if (held_q == CH_LF) begin
				judged.empty_cnt    = sat_inc(state_q.empty_cnt, {1'b0, empty_now});
				judged.effective    = sat_inc(state_q.effective, {1'b0, code_now});
				judged.comment      = sat_inc(state_q.comment,
					{1'b0, state_q.line_slashes && !state_q.in_block});
				judged.pending      = sat_inc(state_q.pending,
					{1'b0, state_q.in_block && !empty_now});
				judged.total        = sat_inc(state_q.total, 2'd1);
				judged.line_empty   = 1'b1;
				judged.line_slashes = 1'b0;
				judged.line_code    = 1'b0;
			end else begin
				judged.line_empty = empty_now;
				judged.line_code  = code_now;
				if (held_q == CH_SLASH && byte_s1 == CH_SLASH) begin
					judged.line_slashes = 1'b1;
				end
				if (held_q == CH_SLASH && byte_s1 == CH_STAR) begin
					judged.in_block = 1'b1;
					judged.comment  = sat_inc(state_q.comment,
						{1'b0, !state_q.line_slashes});
				end
				// Lines held inside the block are credited once it closes.
				if (held_q == CH_STAR && byte_s1 == CH_SLASH) begin
					judged.comment  = sat_add(state_q.comment, state_q.pending);
					judged.in_block = 1'b0;
					judged.pending  = '0;
				end
			end
		end
	end

	// Tracking state: a final byte hands the state on and starts afresh.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SLC_RESET_STATE;
			held_valid_q <= 1'b0;
			held_q       <= '0;
		end else if (en && valid_s1) begin
			if (last_s1) begin
				state_q      <= SLC_RESET_STATE;
				held_valid_q <= 1'b0;
				held_q       <= '0;
			end else begin
				state_q      <= judged;
				held_valid_q <= 1'b1;
				held_q       <= byte_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1 && last_s1) begin
			snap_s2 <= judged;
			byte_s2 <= byte_s1;
		end
	end

	slc_settle u_settle (
		.st        (snap_s2),
		.last_byte (byte_s2),
		.counts    (counts)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			m_data_q <= {counts.comment[OUT_WIDTH-1:0], counts.effective[OUT_WIDTH-1:0],
				counts.empty_cnt[OUT_WIDTH-1:0], counts.total[OUT_WIDTH-1:0]};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the source line classifier. Short files go in one
// byte per item; the four line counts of each file are predicted alongside and
// compared with the result item as it leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import slc_pkg::*;

	typedef bit [7:0] byte_q_t[$];
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	localparam int FILE_ITEMS  = 1000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	// Line counter model: holds one byte back and settles it against the next.
	class line_scoreboard;
		bit [7:0]    held;
		bit          held_ok;
		bit          empty_ln;
		bit          slashes;
		bit          code_ln;
		bit          in_block;
		count_t      pending;
		slc_counts_t tally;
		slc_counts_t counts_q[$];
		int          errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			held     = '0;
			held_ok  = 1'b0;
			empty_ln = 1'b1;
			slashes  = 1'b0;
			code_ln  = 1'b0;
			in_block = 1'b0;
			pending  = '0;
			tally    = '0;
		endfunction

		function count_t bump(count_t a, count_t b);
			logic [COUNT_WIDTH:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
		endfunction

		function void settle(bit [7:0] p, bit [7:0] nxt, bit last);
			if (p != CH_SPACE && p != CH_LF && p != CH_CR) begin
				empty_ln = 1'b0;
				if (p != CH_SLASH && p != CH_STAR && !in_block && !slashes)
					code_ln = 1'b1;
			end
			if (p == CH_LF || last) begin
				if (empty_ln)
					tally.empty_cnt = bump(tally.empty_cnt, 1);
				if (code_ln)
					tally.effective = bump(tally.effective, 1);
				if (slashes && !in_block)
					tally.comment = bump(tally.comment, 1);
				if (in_block && !empty_ln)
					pending = bump(pending, 1);
				tally.total = bump(tally.total, 1);
				empty_ln = 1'b1;
				slashes  = 1'b0;
				code_ln  = 1'b0;
				if (last) begin
					// A trailing line feed opens one more, empty, line.
					if (p == CH_LF) begin
						tally.total     = bump(tally.total, 1);
						tally.empty_cnt = bump(tally.empty_cnt, 1);
					end
					return;
				end
			end
			if (p == CH_SLASH && nxt == CH_SLASH)
				slashes = 1'b1;
			if (p == CH_SLASH && nxt == CH_STAR) begin
				in_block = 1'b1;
				if (!slashes)
					tally.comment = bump(tally.comment, 1);
			end
			if (p == CH_STAR && nxt == CH_SLASH) begin
				tally.comment = bump(tally.comment, pending);
				in_block = 1'b0;
				pending  = '0;
			end
		endfunction

		function void note_input(bit [7:0] b, bit last);
			if (held_ok)
				settle(held, b, 1'b0);
			if (!last) begin
				held    = b;
				held_ok = 1'b1;
			end else begin
				settle(b, '0, 1'b1);
				counts_q.push_back(tally);
				clear();
			end
		endfunction

		function void check_result(logic [127:0] d);
			slc_counts_t want;
			if (counts_q.size() == 0) begin
				$error("result item with no file outstanding: %h", d);
				errors++;
				return;
			end
			want = counts_q.pop_front();
			if (d[31:0] !== want.total) begin
				$error("total_lines: expected %0d, got %0d", want.total, d[31:0]);
				errors++;
			end
			if (d[63:32] !== want.empty_cnt) begin
				$error("empty_lines: expected %0d, got %0d", want.empty_cnt, d[63:32]);
				errors++;
			end
			if (d[95:64] !== want.effective) begin
				$error("effective_lines: expected %0d, got %0d", want.effective, d[95:64]);
				errors++;
			end
			if (d[127:96] !== want.comment) begin
				$error("comment_lines: expected %0d, got %0d", want.comment, d[127:96]);
				errors++;
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata  = '0;
	logic         s_axis_tlast  = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;

	line_scoreboard sb = new();
	idle_mode_e     mode = IDLE_NONE;
	int             items_sent = 0;
	int             file_no = 0;
	int             hold_left = 0;
	bit             hold_req = 1'b0;
	bit             hold_done = 1'b0;
	bit             rx_ready;
	int             drain_cycles;

	source_line_classifier DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit chance(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic bit sender_gap();
		case (mode)
			IDLE_SENDER: return chance(82);
			IDLE_BOTH:   return chance(8);
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stall();
		case (mode)
			IDLE_RECEIVER: return chance(82);
			IDLE_BOTH:     return chance(8);
			default:       return 1'b0;
		endcase
	endfunction

	function automatic byte_q_t text_bytes(string s);
		byte_q_t f;
		for (int i = 0; i < s.len(); i++)
			f.push_back(s[i]);
		return f;
	endfunction

	// Mostly comment markers, line ends and letters, with some raw noise bytes.
	function automatic byte_q_t random_file();
		byte_q_t f;
		int      tokens;
		int      r;
		tokens = $urandom_range(1, 24);
		for (int i = 0; i < tokens; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				f.push_back(CH_SLASH);
				f.push_back(CH_SLASH);
			end else if (r < 20) begin
				f.push_back(CH_SLASH);
				f.push_back(CH_STAR);
			end else if (r < 30) begin
				f.push_back(CH_STAR);
				f.push_back(CH_SLASH);
			end else if (r < 45)
				f.push_back(CH_LF);
			else if (r < 55)
				f.push_back(CH_SPACE);
			else if (r < 60)
				f.push_back(CH_CR);
			else if (r < 65)
				f.push_back(CH_SLASH);
			else if (r < 70)
				f.push_back(CH_STAR);
			else if (r < 90)
				f.push_back(CH_LOWER_A + 8'($urandom_range(0, 25)));
			else
				f.push_back(8'($urandom_range(0, 255)));
		end
		return f;
	endfunction

	task automatic send_item(bit [7:0] b, bit last);
		while (sender_gap()) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_input(b, last);
		items_sent++;
	endtask

	task automatic send_file(byte_q_t f);
		for (int i = 0; i < f.size(); i++)
			send_item(f[i], i == f.size() - 1);
		file_no++;
	endtask

	// Receiver: random stalls, plus one long hold-off counted here.
	initial begin
		forever begin
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rx_ready = 1'b0;
			end else
				rx_ready = !receiver_stall();
			m_axis_tready <= rx_ready;
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
		end
	end

	initial begin
		#5ms;
		$display("tb: errors");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed files: single-byte files, comment kinds, CR, nul and high bytes.
		send_file('{CH_LF});
		send_file('{8'hFF});
		send_file(text_bytes("//x\n"));
		send_file(text_bytes("/*\nq\n*/"));
		send_file(text_bytes(" \r\n"));
		send_file('{CH_SLASH, CH_STAR, 8'h00});
		send_file(text_bytes("x*/"));

		while (items_sent < FILE_ITEMS) begin
			mode = idle_mode_e'((file_no / 5) % 4);
			// Half way, the receiver holds off while the sender keeps offering.
			if (!hold_done && items_sent > FILE_ITEMS / 2) begin
				hold_done = 1'b1;
				mode      = IDLE_NONE;
				hold_req  = 1'b1;
			end
			send_file(random_file());
		end
		s_axis_tvalid <= 1'b0;
		s_axis_tlast  <= 1'b0;

		while (sb.counts_q.size() > 0)
			@(posedge clk);
		drain_cycles = 10;
		repeat (drain_cycles) @(posedge clk);

		if (sb.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/slc_pkg.sv
rtl/slc_settle.sv
rtl/source_line_classifier.sv
sim/tb.sv
